// File: rtl/qdsw_pkg.sv
// ----------------------------------------------------------------------------
// qdsw_pkg
// Shared types, constants and helper functions for the dual quadrature
// decoder with moving-average speed estimate.
// ----------------------------------------------------------------------------
package qdsw_pkg;

   localparam int NUM_SAMPLES_DEFAULT = 8;

   localparam int POS_W    = 32;
   localparam int SCALE_W  = 32;
   localparam int RADIUS_W = 16;
   localparam int CSR_W    = 32;
   localparam int FRAC_SHIFT = 8;
   localparam int EXT_W    = 65;

   localparam logic [SCALE_W-1:0]  ANGULAR_SCALE_RESET = 32'd16777216;
   localparam logic [RADIUS_W-1:0] WHEEL_RADIUS_RESET  = 16'd5120;

   typedef enum logic [0:0] {
      CSR_ANGULAR_SCALE = 1'b0,
      CSR_WHEEL_RADIUS  = 1'b1
   } csr_index_type;

   localparam logic [3:0] CODE_UP_0   = 4'b1101;
   localparam logic [3:0] CODE_UP_1   = 4'b0100;
   localparam logic [3:0] CODE_UP_2   = 4'b0010;
   localparam logic [3:0] CODE_UP_3   = 4'b1011;
   localparam logic [3:0] CODE_DOWN_0 = 4'b1110;
   localparam logic [3:0] CODE_DOWN_1 = 4'b0111;
   localparam logic [3:0] CODE_DOWN_2 = 4'b0001;
   localparam logic [3:0] CODE_DOWN_3 = 4'b1000;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL1,
      ST_SAT1,
      ST_MUL2,
      ST_SAT2,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic take;
      logic tick;
      logic sum_en;
      logic mul1_en;
      logic sat1_en;
      logic mul2_en;
      logic sat2_en;
   } lane_ctl_type;

   function automatic step_type qdsw_step(input logic [3:0] code);
      step_type result;
      case (code)
         CODE_UP_0, CODE_UP_1, CODE_UP_2, CODE_UP_3:         result = STEP_UP;
         CODE_DOWN_0, CODE_DOWN_1, CODE_DOWN_2, CODE_DOWN_3: result = STEP_DOWN;
         default:                                            result = STEP_NONE;
      endcase
      return result;
   endfunction

   function automatic logic signed [POS_W-1:0] qdsw_sat32(input logic signed [EXT_W-1:0] v);
      logic signed [POS_W-1:0] result;
      if (v > EXT_W'(64'sd2147483647)) begin
         result = 32'sh7fffffff;
      end else if (v < EXT_W'(-64'sd2147483648)) begin
         result = 32'sh80000000;
      end else begin
         result = v[POS_W-1:0];
      end
      return result;
   endfunction

endpackage

// File: rtl/qdsw_if.sv
// ----------------------------------------------------------------------------
// qdsw request and response channels
// Valid/ready channels carrying the pin sample request and the decoded
// count and speed response.
// ----------------------------------------------------------------------------
interface qdsw_req_if;
   logic valid;
   logic ready;
   logic left_a;
   logic left_b;
   logic right_a;
   logic right_b;
   logic clear_left;
   logic clear_right;
   logic sample_tick;

   modport source (output valid, left_a, left_b, right_a, right_b, clear_left,
                   clear_right, sample_tick, input ready);
   modport sink (input valid, left_a, left_b, right_a, right_b, clear_left,
                 clear_right, sample_tick, output ready);
endinterface

interface qdsw_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_count;
   logic signed [31:0] right_count;
   logic signed [31:0] left_speed;
   logic signed [31:0] right_speed;
   logic signed [31:0] left_linear;
   logic signed [31:0] right_linear;
   logic               speed_valid;

   modport source (output valid, left_count, right_count, left_speed, right_speed,
                   left_linear, right_linear, speed_valid, input ready);
   modport sink (input valid, left_count, right_count, left_speed, right_speed,
                 left_linear, right_linear, speed_valid, output ready);
endinterface

// File: rtl/qdsw_ram.sv
// ----------------------------------------------------------------------------
// qdsw_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module qdsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/qdsw_lane.sv
// ----------------------------------------------------------------------------
// qdsw_lane
// One encoder lane: x4 decode of the pin pair, position counter, delta
// window with running sum, and the two scaled and saturated speed products.
// ----------------------------------------------------------------------------
module qdsw_lane #(
   parameter int NUM_SAMPLES = qdsw_pkg::NUM_SAMPLES_DEFAULT
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  qdsw_pkg::lane_ctl_type                               ctl,
   input  logic                                                 pin_a,
   input  logic                                                 pin_b,
   input  logic                                                 clear,
   input  logic [$clog2(NUM_SAMPLES > 1 ? NUM_SAMPLES : 2)-1:0] slot,
   input  logic [qdsw_pkg::SCALE_W-1:0]                         angular_scale,
   input  logic [qdsw_pkg::RADIUS_W-1:0]                        wheel_radius,
   output logic [qdsw_pkg::POS_W-1:0]                           count,
   output logic signed [qdsw_pkg::POS_W-1:0]                    speed,
   output logic signed [qdsw_pkg::POS_W-1:0]                    linear
);

   import qdsw_pkg::*;

   localparam int PROD2_W = POS_W + RADIUS_W + 1;

   logic [1:0]              last_pins_ff, last_pins_in;
   logic [POS_W-1:0]        position_ff, position_in;
   logic [POS_W-1:0]        previous_ff;
   logic [POS_W-1:0]        delta_ff;
   logic [POS_W-1:0]        sum_ff, sum_in;
   logic [NUM_SAMPLES-1:0]  valid_ff;
   logic [POS_W-1:0]        rd_data;
   logic [POS_W-1:0]        old_delta;
   logic signed [EXT_W-1:0] prod1_ff;
   logic signed [POS_W-1:0] speed_ff;
   logic signed [PROD2_W-1:0] prod2_ff;
   logic signed [POS_W-1:0] linear_ff;
   logic [POS_W-1:0]        stepped;
   step_type                step;

   always_comb begin
      step = qdsw_step({last_pins_ff, pin_a, pin_b});
      case (step)
         STEP_UP:   stepped = position_ff + POS_W'(1);
         STEP_DOWN: stepped = position_ff - POS_W'(1);
         default:   stepped = position_ff;
      endcase
      if (ctl.take) begin
         last_pins_in = {pin_a, pin_b};
         position_in  = clear ? '0 : stepped;
      end else begin
         last_pins_in = last_pins_ff;
         position_in  = position_ff;
      end
      old_delta = valid_ff[slot] ? rd_data : '0;
      sum_in    = sum_ff + delta_ff - old_delta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pins_ff <= '0;
         position_ff  <= '0;
         previous_ff  <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
      end else begin
         last_pins_ff <= last_pins_in;
         position_ff  <= position_in;
         if (ctl.take && ctl.tick) begin
            previous_ff <= position_in;
         end
         if (ctl.sum_en) begin
            sum_ff         <= sum_in;
            valid_ff[slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take && ctl.tick) begin
         delta_ff <= previous_ff - position_in;
      end
      if (ctl.mul1_en) begin
         prod1_ff <= EXT_W'($signed(sum_ff)) * EXT_W'($signed({1'b0, angular_scale}));
      end
      if (ctl.sat1_en) begin
         speed_ff <= qdsw_sat32(prod1_ff >>> FRAC_SHIFT);
      end
      if (ctl.mul2_en) begin
         prod2_ff <= PROD2_W'(speed_ff) * PROD2_W'($signed({1'b0, wheel_radius}));
      end
      if (ctl.sat2_en) begin
         linear_ff <= qdsw_sat32(EXT_W'(prod2_ff >>> FRAC_SHIFT));
      end
   end

   qdsw_ram #(
      .WIDTH (POS_W),
      .DEPTH (NUM_SAMPLES)
   ) u_window (
      .clock   (clock),
      .wr_en   (ctl.sum_en),
      .wr_addr (slot),
      .wr_data (delta_ff),
      .rd_en   (ctl.take && ctl.tick),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   assign count  = position_in;
   assign speed  = speed_ff;
   assign linear = linear_ff;

endmodule

// File: rtl/quadrature_decoder_speed_window.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_speed_window
// Two x4 quadrature decoder lanes with a moving-average speed window; the
// sequencer steps both lanes together and merges their results into one
// registered response.
//
//   channel   direction  handshake          contents
//   req_bus   in         valid/ready        pin levels, clear flags, tick
//   rsp_bus   out        valid/ready        counts, speeds, speed_valid
//   csr_*     in         write enable only  angular_scale, wheel_radius
//
// A request without a sample tick is taken every cycle while the response
// register is free or being emptied; its response appears the next cycle.
// A request with a sample tick steps through the window memory read, sum
// update, then two multiply and saturate pairs, then the response load.
// Reset clears positions, sums, window valid bits and the response valid flag.
// A stalled response holds the sequencer before new requests are taken.
// ----------------------------------------------------------------------------
module quadrature_decoder_speed_window #(
   parameter int NUM_SAMPLES = qdsw_pkg::NUM_SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   qdsw_req_if.sink                   req_bus,
   qdsw_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  qdsw_pkg::csr_index_type    csr_index,
   input  logic [qdsw_pkg::CSR_W-1:0] csr_wdata
);

   import qdsw_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SAMPLES > 1 ? NUM_SAMPLES : 2);

   state_type             state_ff, state_in;
   lane_ctl_type          ctl;
   logic                  out_free;
   logic                  take;
   logic                  load_direct;
   logic                  load_tick;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SCALE_W-1:0]    scale_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic [POS_W-1:0]      left_count, right_count;
   logic signed [POS_W-1:0] left_speed, right_speed;
   logic signed [POS_W-1:0] left_linear, right_linear;
   logic                  rsp_valid_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in      = state_ff;
      ctl           = '0;
      req_bus.ready = 1'b0;
      take          = 1'b0;
      load_direct   = 1'b0;
      load_tick     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = out_free;
            take          = req_bus.valid && out_free;
            ctl.take      = take;
            ctl.tick      = req_bus.sample_tick;
            if (take) begin
               if (req_bus.sample_tick) begin
                  state_in = ST_SUM;
               end else begin
                  load_direct = 1'b1;
               end
            end
         end
         ST_SUM: begin
            ctl.sum_en = 1'b1;
            state_in   = ST_MUL1;
         end
         ST_MUL1: begin
            ctl.mul1_en = 1'b1;
            state_in    = ST_SAT1;
         end
         ST_SAT1: begin
            ctl.sat1_en = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            ctl.mul2_en = 1'b1;
            state_in    = ST_SAT2;
         end
         ST_SAT2: begin
            ctl.sat2_en = 1'b1;
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) begin
               load_tick = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         scale_ff  <= ANGULAR_SCALE_RESET;
         radius_ff <= WHEEL_RADIUS_RESET;
      end else begin
         if (ctl.sum_en) begin
            slot_ff <= (slot_ff == SLOT_W'(NUM_SAMPLES - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ANGULAR_SCALE: scale_ff  <= csr_wdata[SCALE_W-1:0];
               CSR_WHEEL_RADIUS:  radius_ff <= csr_wdata[RADIUS_W-1:0];
               default:           scale_ff  <= scale_ff;
            endcase
         end
      end
   end

   qdsw_lane #(
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_left (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .pin_a         (req_bus.left_a),
      .pin_b         (req_bus.left_b),
      .clear         (req_bus.clear_left),
      .slot          (slot_ff),
      .angular_scale (scale_ff),
      .wheel_radius  (radius_ff),
      .count         (left_count),
      .speed         (left_speed),
      .linear        (left_linear)
   );

   qdsw_lane #(
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_right (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .pin_a         (req_bus.right_a),
      .pin_b         (req_bus.right_b),
      .clear         (req_bus.clear_right),
      .slot          (slot_ff),
      .angular_scale (scale_ff),
      .wheel_radius  (radius_ff),
      .count         (right_count),
      .speed         (right_speed),
      .linear        (right_linear)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_direct || load_tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct || load_tick) begin
         rsp_bus.left_count  <= $signed(left_count);
         rsp_bus.right_count <= $signed(right_count);
         rsp_bus.speed_valid <= load_tick;
         if (load_tick) begin
            rsp_bus.left_speed   <= left_speed;
            rsp_bus.right_speed  <= right_speed;
            rsp_bus.left_linear  <= left_linear;
            rsp_bus.right_linear <= right_linear;
         end else begin
            rsp_bus.left_speed   <= '0;
            rsp_bus.right_speed  <= '0;
            rsp_bus.left_linear  <= '0;
            rsp_bus.right_linear <= '0;
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

endmodule
